// ----- hw/rtl/bracket_graph_to_marker_encoder_unit_defines.svh -----
// Assertion macros shared by the marker encoder RTL.
// No dependencies; expects aclk and aresetn in the including scope.
`ifndef BRACKET_GRAPH_TO_MARKER_ENCODER_UNIT_DEFINES_SVH
`define BRACKET_GRAPH_TO_MARKER_ENCODER_UNIT_DEFINES_SVH

// Condition that must hold on every clock edge out of reset.
`define BGME_ASSERT_ALWAYS(lbl, cond) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (cond)) \
        else $error("invariant violated");

// Same-cycle implication.
`define BGME_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("implication violated");

// Next-cycle implication.
`define BGME_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("next-cycle implication violated");

`endif

// ----- hw/rtl/bgme_pkg.sv -----
// Shared constants and helpers for the bracket graph marker encoder.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package bgme_pkg;

    localparam int NEST_DEPTH_DEF = 64;
    localparam int MARKER_W       = 32;
    localparam int ERR_W          = 3;
    localparam int CHAR_W         = 8;

    localparam logic [ERR_W-1:0] ERR_OK       = 3'd0;
    localparam logic [ERR_W-1:0] ERR_BAD_CHAR = 3'd1;
    localparam logic [ERR_W-1:0] ERR_EMPTY    = 3'd2;
    localparam logic [ERR_W-1:0] ERR_FULL     = 3'd3;
    localparam logic [ERR_W-1:0] ERR_OVERFLOW = 3'd4;

    localparam logic [CHAR_W-1:0] CHAR_OPEN  = 8'h5B; // '['
    localparam logic [CHAR_W-1:0] CHAR_CLOSE = 8'h5D; // ']'
    localparam logic [CHAR_W-1:0] CHAR_COMMA = 8'h2C; // ','

    localparam logic [MARKER_W-1:0] SITE_INIT  = 32'd3;
    localparam logic [MARKER_W-1:0] SITE_STEP  = 32'd2;
    // Largest marker that may still be stepped without the next one
    // (plus one) leaving 32 bits.
    localparam logic [MARKER_W-1:0] SITE_LIMIT = 32'hFFFF_FFFB;

    // Nucleotide to base code, 0 for anything else.
    function automatic logic [2:0] base_code(input logic [CHAR_W-1:0] ch);
        logic [2:0] code;
        case (ch)
            8'h41, 8'h61: code = 3'd1; // A a
            8'h43, 8'h63: code = 3'd2; // C c
            8'h47, 8'h67: code = 3'd3; // G g
            8'h54, 8'h74: code = 3'd4; // T t
            default:      code = 3'd0;
        endcase
        return code;
    endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/bracket_graph_to_marker_encoder_unit.sv -----
// Top level of the bracket graph to marker encoder.
// Depends on bgme_pkg, bgme_ram and the assertion macro header.
//
// Usage:
//   Input channel s_*: one beat per character. s_tdata carries symbol_char,
//   s_tuser carries start_flag (set on the first character of a string,
//   which empties the nesting stack and sets the site marker back to 3).
//   Output channel m_*: exactly one beat per input beat, in order.
//   m_tdata carries marker_value, m_tuser carries error_code.
//   The result of a beat accepted at an edge is registered and valid on
//   m_tvalid right after that edge.
//   Throughput: one beat per cycle while the receiver keeps m_tready high.
//   The top of the nesting stack lives in a register and the entry below
//   it is prefetched from the stack RAM every cycle, so push, pop and peek
//   never wait on the RAM; the single result register sets the figure.
//   Stall: while m_tvalid is high and m_tready is low, s_tready drops and
//   the result holds; input is taken again in the cycle the result goes.
//   Errors (bad character, empty stack, full stack, marker overflow) give
//   marker 0 and a nonzero error code; only a start flag changes state.
//   Reset (aresetn low, synchronous): empties the output register, sets
//   the stack depth to 0 and the marker to 3. The stack RAM needs no
//   clearing pass; entries are only used after being pushed.
`timescale 1ns / 1ps
`default_nettype none
`include "bracket_graph_to_marker_encoder_unit_defines.svh"

module bracket_graph_to_marker_encoder_unit #(
    parameter int NEST_DEPTH = bgme_pkg::NEST_DEPTH_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // input channel
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] symbol_char
    input  wire logic [0:0]  s_tuser,   // [0] start_flag
    // result channel
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,   // [31:0] marker_value
    output logic [2:0]       m_tuser    // [2:0] error_code
);

    localparam int DW = $clog2(NEST_DEPTH + 1);
    localparam int AW = (NEST_DEPTH > 1) ? $clog2(NEST_DEPTH) : 1;
    localparam int MW = bgme_pkg::MARKER_W;
    localparam int EW = bgme_pkg::ERR_W;

    // ---------------------------------------------------------------
    // State
    // ---------------------------------------------------------------
    logic [DW-1:0] depth_reg,  depth_next;   // open sites
    logic [MW-1:0] site_reg,   site_next;    // last odd marker issued
    logic [MW-1:0] top_reg,    top_next;     // top of the nesting stack
    logic          bypass_sel_reg, bypass_sel_next;
    logic [MW-1:0] bypass_data_reg;

    logic          m_tvalid_reg, m_tvalid_next;
    logic [MW-1:0] marker_reg;
    logic [EW-1:0] err_reg;

    logic          accept;
    logic [DW-1:0] eff_depth;
    logic [MW-1:0] eff_site;
    logic [MW-1:0] below;            // stack entry under the top
    logic [MW-1:0] value;
    logic [EW-1:0] err;
    logic          push_wr;
    logic [2:0]    base;
    logic [DW:0]   wr_addr_wide;
    logic [DW:0]   rd_addr_wide;
    logic [DW-1:0] depth_sel;
    logic [AW-1:0] wr_addr;
    logic [AW-1:0] rd_addr;
    logic          wr_en;
    logic [MW-1:0] ram_rd_data;

    // Take a new beat whenever the result register is free or draining.
    assign s_tready = !m_tvalid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    // A start beat sees an empty stack and the initial marker.
    assign eff_depth = s_tuser[0] ? '0 : depth_reg;
    assign eff_site  = s_tuser[0] ? bgme_pkg::SITE_INIT : site_reg;
    assign base      = bgme_pkg::base_code(s_tdata);

    // Prefetched entry under the top, with a bypass for the entry that
    // was written at the same edge it was read.
    assign below = bypass_sel_reg ? bypass_data_reg : ram_rd_data;

    // ---------------------------------------------------------------
    // Character decode and stack update
    // ---------------------------------------------------------------
    always_comb begin
        err        = bgme_pkg::ERR_OK;
        value      = '0;
        depth_next = eff_depth;
        site_next  = eff_site;
        top_next   = top_reg;
        push_wr    = 1'b0;
        case (s_tdata) inside
            bgme_pkg::CHAR_OPEN: begin
                if (eff_depth == DW'(NEST_DEPTH)) begin
                    err = bgme_pkg::ERR_FULL;
                end else if (eff_site > bgme_pkg::SITE_LIMIT) begin
                    err = bgme_pkg::ERR_OVERFLOW;
                end else begin
                    site_next  = eff_site + bgme_pkg::SITE_STEP;
                    top_next   = site_next;
                    depth_next = eff_depth + DW'(1);
                    value      = site_next;
                    // spill the old top into the RAM unless the stack was empty
                    push_wr    = (eff_depth != '0);
                end
            end
            bgme_pkg::CHAR_CLOSE, bgme_pkg::CHAR_COMMA: begin
                if (eff_depth == '0) begin
                    err = bgme_pkg::ERR_EMPTY;
                end else begin
                    value = top_reg + MW'(1);
                    if (s_tdata == bgme_pkg::CHAR_CLOSE) begin
                        depth_next = eff_depth - DW'(1);
                        top_next   = below;
                    end
                end
            end
            default: begin
                if (base == 3'd0) begin
                    err = bgme_pkg::ERR_BAD_CHAR;
                end else begin
                    value = MW'(base);
                end
            end
        endcase
    end

    // ---------------------------------------------------------------
    // Stack RAM addressing: write at depth-1, read at next depth-2
    // ---------------------------------------------------------------
    assign depth_sel    = accept ? depth_next : depth_reg;
    assign wr_addr_wide = {1'b0, eff_depth} - (DW + 1)'(1);
    assign rd_addr_wide = {1'b0, depth_sel} - (DW + 1)'(2);
    assign wr_addr      = wr_addr_wide[AW-1:0];
    assign rd_addr      = rd_addr_wide[AW-1:0];
    assign wr_en        = accept && push_wr;

    assign bypass_sel_next = wr_en && (wr_addr == rd_addr);
    assign m_tvalid_next   = accept ? 1'b1 : (m_tready ? 1'b0 : m_tvalid_reg);

    bgme_ram #(
        .WIDTH (MW),
        .DEPTH (NEST_DEPTH)
    ) u_stack_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (top_reg),
        .rd_addr (rd_addr),
        .rd_data (ram_rd_data)
    );

    // ---------------------------------------------------------------
    // Registers
    // ---------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            depth_reg      <= '0;
            site_reg       <= bgme_pkg::SITE_INIT;
            bypass_sel_reg <= 1'b0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            bypass_sel_reg <= bypass_sel_next;
            m_tvalid_reg   <= m_tvalid_next;
            if (accept) begin
                depth_reg <= depth_next;
                site_reg  <= site_next;
            end
        end
    end

    // Payload: no reset needed.
    always_ff @(posedge aclk) begin
        bypass_data_reg <= top_reg;
        if (accept) begin
            top_reg    <= top_next;
            marker_reg <= value;
            err_reg    <= err;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = marker_reg;
    assign m_tuser  = err_reg;

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    `BGME_ASSERT_ALWAYS(a_depth_bound, depth_reg <= DW'(NEST_DEPTH))
    `BGME_ASSERT_ALWAYS(a_site_odd, site_reg[0] == 1'b1)
    `BGME_ASSERT_IMPL(a_err_zero_marker, m_tvalid && (m_tuser != bgme_pkg::ERR_OK), m_tdata == '0)
    `BGME_ASSERT_NEXT(a_push_top, accept && (s_tdata == bgme_pkg::CHAR_OPEN) && (err == bgme_pkg::ERR_OK), (top_reg == site_reg) && (m_tdata == site_reg))

endmodule

`default_nettype wire

// ----- hw/rtl/bgme_ram.sv -----
// Generic simple dual-port RAM, one write and one registered read port.
// Depends on bgme_pkg for default sizes.
`timescale 1ns / 1ps
`default_nettype none

module bgme_ram #(
    parameter int WIDTH = bgme_pkg::MARKER_W,
    parameter int DEPTH = bgme_pkg::NEST_DEPTH_DEF,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             aclk,
    input  wire logic             wr_en,
    input  wire logic [AW-1:0]    wr_addr,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic [AW-1:0]    rd_addr,
    output logic      [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Read-first: a read at the address being written returns old data.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ----- verif/tb.sv -----
// Self-checking testbench for bracket_graph_to_marker_encoder_unit.
// Drives character beats, predicts each marker and error code in a scoreboard class,
// and checks every result beat in order. Depends on bgme_pkg and the unit RTL.
`timescale 1ns / 1ps

module tb;

    localparam int STACK_DEPTH  = bgme_pkg::NEST_DEPTH_DEF;
    localparam int RESET_CYCLES = 4;
    localparam int PHASE_ITEMS  = 325;
    localparam int HOLD_CYCLES  = 200;
    localparam int DRAIN_LIMIT  = 20000;
    localparam int TAIL_CYCLES  = 4;
    localparam int PRINT_LIMIT  = 40;

    // Highest marker a new site may take, so that marker plus one stays in 32 bits.
    localparam logic [31:0] MARKER_CEILING = 32'hFFFF_FFFD;

    localparam logic [7:0] CH_UP_A = 8'h41;
    localparam logic [7:0] CH_UP_C = 8'h43;
    localparam logic [7:0] CH_UP_G = 8'h47;
    localparam logic [7:0] CH_UP_T = 8'h54;
    localparam logic [7:0] CH_LO_A = 8'h61;
    localparam logic [7:0] CH_LO_C = 8'h63;
    localparam logic [7:0] CH_LO_G = 8'h67;
    localparam logic [7:0] CH_LO_T = 8'h74;
    localparam logic [7:0] CH_LO_X = 8'h78;
    localparam logic [7:0] CH_UP_Z = 8'h5A;
    localparam logic [7:0] CH_NUL  = 8'h00;
    localparam logic [7:0] CH_ALL1 = 8'hFF;

    typedef struct packed {
        logic [31:0] marker;
        logic [2:0]  code;
    } marker_beat_t;

    // Marker scoreboard: its own copy of the nesting stack and the site marker,
    // plus the queue of markers still owed by the block.
    class marker_tracker;
        logic [31:0]  nest [STACK_DEPTH];
        int           depth;
        logic [31:0]  site;
        marker_beat_t pending_markers [$];
        int           fails;

        function new();
            depth = 0;
            site  = bgme_pkg::SITE_INIT;
            fails = 0;
        endfunction

        task report(string msg);
            fails++;
            if (fails <= PRINT_LIMIT) $display("MISMATCH at %0t: %s", $realtime, msg);
        endtask

        function int pending();
            return pending_markers.size();
        endfunction

        // Encode one accepted character beat and queue the marker it owes.
        function void note_char(logic [7:0] ch, logic start);
            marker_beat_t beat;
            beat.marker = '0;
            beat.code   = bgme_pkg::ERR_OK;
            if (start) begin
                depth = 0;
                site  = bgme_pkg::SITE_INIT;
            end
            if (ch == bgme_pkg::CHAR_OPEN) begin
                if (depth >= STACK_DEPTH) begin
                    beat.code = bgme_pkg::ERR_FULL;
                end else if (site > MARKER_CEILING - bgme_pkg::SITE_STEP) begin
                    beat.code = bgme_pkg::ERR_OVERFLOW;
                end else begin
                    site        = site + bgme_pkg::SITE_STEP;
                    nest[depth] = site;
                    depth++;
                    beat.marker = site;
                end
            end else if (ch == bgme_pkg::CHAR_CLOSE || ch == bgme_pkg::CHAR_COMMA) begin
                if (depth == 0) begin
                    beat.code = bgme_pkg::ERR_EMPTY;
                end else begin
                    beat.marker = nest[depth-1] + 32'd1;
                    if (ch == bgme_pkg::CHAR_CLOSE) depth--;
                end
            end else begin
                case (ch)
                    CH_UP_A, CH_LO_A: beat.marker = 32'd1;
                    CH_UP_C, CH_LO_C: beat.marker = 32'd2;
                    CH_UP_G, CH_LO_G: beat.marker = 32'd3;
                    CH_UP_T, CH_LO_T: beat.marker = 32'd4;
                    default:          beat.code   = bgme_pkg::ERR_BAD_CHAR;
                endcase
            end
            pending_markers.insert(pending_markers.size(), beat);
        endfunction

        // Compare one result beat against the oldest owed marker.
        task check_marker(logic [31:0] marker, logic [2:0] code);
            marker_beat_t want;
            if (pending_markers.size() == 0) begin
                report($sformatf("result beat %0d/%0d with no marker owed", marker, code));
                return;
            end
            want = pending_markers.pop_front();
            if (marker !== want.marker)
                report($sformatf("marker %0d, want %0d", marker, want.marker));
            if (code !== want.code)
                report($sformatf("error code %0d, want %0d", code, want.code));
        endtask

        task close_out();
            if (pending_markers.size() != 0)
                report($sformatf("%0d markers never arrived", pending_markers.size()));
        endtask
    endclass

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = '0;   // [7:0] symbol_char
    logic [0:0]  s_tuser  = '0;   // [0] start_flag
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;         // [31:0] marker_value
    logic [2:0]  m_tuser;         // [2:0] error_code

    marker_tracker tracker;

    // Idle percentages for the current phase, and the long receiver hold-off.
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_asked     = 0;
    int hold_granted   = 0;
    int hold_left      = 0;
    int chars_sent     = 0;

    bracket_graph_to_marker_encoder_unit #(
        .NEST_DEPTH (STACK_DEPTH)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #5 aclk = ~aclk;

    // Receiver: stall at random per phase; on request, hold off for a long
    // stretch so the result register fills and the block stalls its input.
    always @(posedge aclk) begin
        if (hold_left > 0) begin
            m_tready  <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_granted != hold_asked) begin
            m_tready     <= 1'b0;
            hold_left    <= HOLD_CYCLES;
            hold_granted <= hold_asked;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Monitor: check each result beat first, then note each accepted input beat.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready) tracker.check_marker(m_tdata, m_tuser);
            if (s_tvalid && s_tready) tracker.note_char(s_tdata, s_tuser[0]);
        end
    end

    // Offer one character beat, with random idle cycles ahead of it, and hold
    // it until the block takes it.
    task automatic send_char(input logic [7:0] ch, input logic start);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= ch;
        s_tuser  <= start;
        do @(posedge aclk); while (!s_tready);
        chars_sent++;
    endtask

    // Drop valid and wait until every owed marker has come back.
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (tracker.pending() != 0);
    endtask

    function automatic logic [7:0] pick_base();
        logic [7:0] ch;
        case ($urandom_range(7))
            0: ch = CH_UP_A;
            1: ch = CH_LO_A;
            2: ch = CH_UP_C;
            3: ch = CH_LO_C;
            4: ch = CH_UP_G;
            5: ch = CH_LO_G;
            6: ch = CH_UP_T;
            default: ch = CH_LO_T;
        endcase
        return ch;
    endfunction

    // One graph string. Mostly well formed with random content; some strings
    // nest past the stack depth, and a few characters are noise.
    task automatic send_string();
        int         steps;
        int         opens;
        int         k;
        int         roll;
        logic       start;
        logic [7:0] ch;
        opens = 0;
        start = ($urandom_range(9) != 0);
        if ($urandom_range(14) == 0) begin
            // Deep nesting: push to near or past a full stack, then close every push
            // asked for, so any surplus closes also run into an empty stack.
            steps = $urandom_range(STACK_DEPTH - 2, STACK_DEPTH + 6);
            for (k = 0; k < steps; k++) begin
                send_char(bgme_pkg::CHAR_OPEN, start);
                start = 1'b0;
                opens++;
                if ($urandom_range(3) == 0) send_char(pick_base(), 1'b0);
            end
        end else begin
            steps = $urandom_range(3, 30);
            for (k = 0; k < steps; k++) begin
                roll = $urandom_range(99);
                if (roll < 8) begin
                    ch = 8'($urandom_range(255));
                    send_char(ch, start | ($urandom_range(19) == 0));
                end else if (roll < 35 && opens < STACK_DEPTH) begin
                    send_char(bgme_pkg::CHAR_OPEN, start);
                    opens++;
                end else if (roll < 50 && opens > 0) begin
                    send_char(bgme_pkg::CHAR_COMMA, start);
                end else if (roll < 62 && opens > 0) begin
                    send_char(bgme_pkg::CHAR_CLOSE, start);
                    opens--;
                end else begin
                    send_char(pick_base(), start);
                end
                start = 1'b0;
            end
        end
        while (opens > 0) begin
            if ($urandom_range(4) == 0) send_char(bgme_pkg::CHAR_COMMA, 1'b0);
            send_char(bgme_pkg::CHAR_CLOSE, 1'b0);
            opens--;
        end
    endtask

    // Directed: every base in both cases, site open/allele/close at two levels,
    // closes and commas on an empty stack, bad characters at the byte extremes,
    // and the start flag with a push and with an error in the same beat.
    // Marker overflow needs about two billion pushes and is left to the predictor.
    task automatic run_directed();
        send_char(CH_UP_A, 1'b1);
        send_char(CH_LO_A, 1'b0);
        send_char(CH_UP_C, 1'b0);
        send_char(CH_LO_C, 1'b0);
        send_char(CH_UP_G, 1'b0);
        send_char(CH_LO_G, 1'b0);
        send_char(CH_UP_T, 1'b0);
        send_char(CH_LO_T, 1'b0);
        send_char(bgme_pkg::CHAR_COMMA, 1'b0);
        send_char(bgme_pkg::CHAR_CLOSE, 1'b0);
        send_char(bgme_pkg::CHAR_OPEN, 1'b0);
        send_char(bgme_pkg::CHAR_COMMA, 1'b0);
        send_char(bgme_pkg::CHAR_OPEN, 1'b0);
        send_char(CH_LO_G, 1'b0);
        send_char(bgme_pkg::CHAR_CLOSE, 1'b0);
        send_char(bgme_pkg::CHAR_CLOSE, 1'b0);
        send_char(bgme_pkg::CHAR_CLOSE, 1'b0);
        send_char(CH_LO_X, 1'b0);
        send_char(CH_NUL, 1'b0);
        send_char(CH_ALL1, 1'b0);
        send_char(bgme_pkg::CHAR_OPEN, 1'b0);
        send_char(bgme_pkg::CHAR_OPEN, 1'b1);
        send_char(CH_UP_Z, 1'b1);
        send_char(bgme_pkg::CHAR_COMMA, 1'b0);
        send_char(bgme_pkg::CHAR_OPEN, 1'b0);
    endtask

    initial begin
        int phase;
        int target;
        int waited;
        logic pressed;
        tracker = new();
        // Hold reset low, then release it at a rising edge.
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;

        run_directed();
        wait_drained();

        for (phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 80; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 80; end
                default: begin send_idle_pct = 21; recv_stall_pct = 21; end
            endcase
            target  = chars_sent + PHASE_ITEMS;
            pressed = 1'b0;
            while (chars_sent < target) begin
                send_string();
                // Halfway through, apply back-pressure: a long receiver
                // hold-off in the busy phases, a full drain in the others.
                if (!pressed && chars_sent > target - PHASE_ITEMS / 2) begin
                    pressed = 1'b1;
                    if (phase == 0 || phase == 3) hold_asked++;
                    else wait_drained();
                end
            end
            wait_drained();
        end

        // Stop offering and wait out every owed marker before the final check.
        s_tvalid <= 1'b0;
        waited = 0;
        while (tracker.pending() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge aclk);
            waited++;
        end
        repeat (TAIL_CYCLES) @(posedge aclk);
        tracker.close_out();
        if (tracker.fails == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    // Watchdog: end a hung run well past the slowest correct one.
    initial begin
        #5_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ----- bracket_graph_to_marker_encoder_unit.f -----
+incdir+hw/rtl
hw/rtl/bgme_pkg.sv
hw/rtl/bgme_ram.sv
hw/rtl/bracket_graph_to_marker_encoder_unit.sv
verif/tb.sv
